// ===== design/frcb_pkg.sv =====
// package for the floppy read command builder
// holds the configuration and queue entry types, register indexes and command codes
// no dependencies
package frcb_pkg;

  localparam int unsigned CfgIdxW = 3;
  localparam int unsigned CfgDataW = 8;

  localparam logic [CfgIdxW-1:0] REG_SECTORS_PER_TRACK = 3'd0;
  localparam logic [CfgIdxW-1:0] REG_HEAD_COUNT        = 3'd1;
  localparam logic [CfgIdxW-1:0] REG_TRACK_COUNT       = 3'd2;
  localparam logic [CfgIdxW-1:0] REG_TRACK_STRETCH     = 3'd3;
  localparam logic [CfgIdxW-1:0] REG_GAP_LENGTH        = 3'd4;

  localparam logic [5:0] SPT_RESET = 6'd18;
  localparam logic [1:0] HEADS_RESET = 2'd2;
  localparam logic [7:0] TRACKS_RESET = 8'd80;
  localparam logic       STRETCH_RESET = 1'b0;
  localparam logic [7:0] GAP_RESET = 8'h1b;

  localparam logic [7:0] CMD_RECALIBRATE = 8'h07;
  localparam logic [7:0] CMD_SEEK        = 8'h0f;
  localparam logic [7:0] CMD_READ        = 8'he6;
  localparam logic [7:0] SIZE_CODE_512   = 8'h02;
  localparam logic [7:0] DATA_LENGTH     = 8'hff;

  // position of each word in the command sequence
  localparam logic [3:0] IDX_RECAL_OP    = 4'd0;
  localparam logic [3:0] IDX_RECAL_DRIVE = 4'd1;
  localparam logic [3:0] IDX_SEEK_OP     = 4'd2;
  localparam logic [3:0] IDX_SEEK_SEL    = 4'd3;
  localparam logic [3:0] IDX_SEEK_TRACK  = 4'd4;
  localparam logic [3:0] IDX_READ_OP     = 4'd5;
  localparam logic [3:0] IDX_READ_DRIVE  = 4'd6;
  localparam logic [3:0] IDX_READ_TRACK  = 4'd7;
  localparam logic [3:0] IDX_READ_HEAD   = 4'd8;
  localparam logic [3:0] IDX_READ_SECTOR = 4'd9;
  localparam logic [3:0] IDX_READ_SIZE   = 4'd10;
  localparam logic [3:0] IDX_READ_EOT    = 4'd11;
  localparam logic [3:0] IDX_READ_GAP    = 4'd12;
  localparam logic [3:0] IDX_READ_DTL    = 4'd13;

  typedef struct packed {
    logic [5:0] sectors_per_track;
    logic [1:0] head_count;
    logic [7:0] track_count;
    logic       track_stretch;
    logic [7:0] gap_length;
  } cfg_t;

  typedef struct packed {
    logic       err;
    logic [1:0] drive;
    logic [7:0] track;
    logic [1:0] head;
    logic [5:0] sector;
  } entry_t;

endpackage

// ===== design/frcb_front.sv =====
// front end: accepts requests, range checks them and splits the sector number
// into track, head and sector with a bit-serial divider; uses frcb_pkg
module frcb_front import frcb_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  cfg_t        cfg_i,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [1:0]  drive_i,
  input  logic [14:0] sector_number_i,
  input  logic        buffer_present_i,
  output logic        push_o,
  output entry_t      push_entry_o,
  input  logic        push_ready_i
);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_DIV  = 2'd1;
  localparam logic [1:0] ST_PUSH = 2'd2;

  logic [1:0]  state_q, state_d;
  logic [2:0]  cnt_q, cnt_d;
  logic [7:0]  rem_q, rem_d;
  logic [7:0]  low_q, low_d;
  logic [7:0]  quo_q, quo_d;
  logic [1:0]  drive_q, drive_d;
  logic        err_q, err_d;

  logic [7:0]  divisor;
  logic [15:0] capacity;
  logic        reject;
  logic        accept;
  logic [8:0]  trial;
  logic        ge;
  logic [7:0]  spt_x1, spt_x2;
  logic [7:0]  sec_rem;
  logic [1:0]  head;

  // blocks per cylinder; the track quotient always fits eight bits once in range
  assign divisor  = {2'b00, cfg_i.sectors_per_track} * {6'b000000, cfg_i.head_count};
  assign capacity = {8'h00, divisor} * {8'h00, cfg_i.track_count};
  assign reject   = !buffer_present_i || ({1'b0, sector_number_i} >= capacity);

  assign push_o     = (state_q == ST_PUSH);
  assign in_ready_o = (state_q == ST_IDLE) || (push_o && push_ready_i);
  assign accept     = in_valid_i && in_ready_o;

  assign trial = {rem_q, low_q[7]};
  assign ge    = trial >= {1'b0, divisor};

  // head and sector from the remainder within the cylinder
  assign spt_x1 = {2'b00, cfg_i.sectors_per_track};
  assign spt_x2 = {1'b0, cfg_i.sectors_per_track, 1'b0};

  always_comb begin
    if (rem_q >= spt_x2) begin
      head    = 2'd2;
      sec_rem = rem_q - spt_x2;
    end else if (rem_q >= spt_x1) begin
      head    = 2'd1;
      sec_rem = rem_q - spt_x1;
    end else begin
      head    = 2'd0;
      sec_rem = rem_q;
    end
  end

  always_comb begin
    push_entry_o.err    = err_q;
    push_entry_o.drive  = drive_q;
    push_entry_o.track  = quo_q;
    push_entry_o.head   = head;
    push_entry_o.sector = sec_rem[5:0] + 6'd1;
  end

  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    rem_d   = rem_q;
    low_d   = low_q;
    quo_d   = quo_q;
    drive_d = drive_q;
    err_d   = err_q;
    case (state_q)
      ST_DIV: begin
        rem_d = ge ? 8'(trial - {1'b0, divisor}) : trial[7:0];
        quo_d = {quo_q[6:0], ge};
        low_d = {low_q[6:0], 1'b0};
        cnt_d = cnt_q + 3'd1;
        if (cnt_q == 3'd7) begin
          state_d = ST_PUSH;
        end
      end
      ST_PUSH: begin
        if (push_ready_i) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
    if (accept) begin
      drive_d = drive_i;
      err_d   = reject;
      rem_d   = {1'b0, sector_number_i[14:8]};
      low_d   = sector_number_i[7:0];
      quo_d   = 8'h00;
      cnt_d   = 3'd0;
      state_d = reject ? ST_PUSH : ST_DIV;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      cnt_q   <= 3'd0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q   <= rem_d;
    low_q   <= low_d;
    quo_q   <= quo_d;
    drive_q <= drive_d;
    err_q   <= err_d;
  end

endmodule

// ===== design/frcb_fifo.sv =====
// short queue of decoded requests between the front and back ends
// uses frcb_pkg for the entry type
module frcb_fifo import frcb_pkg::*; #(
  parameter int unsigned Depth = 2
) (
  input  logic   clk_i,
  input  logic   rst_ni,
  input  logic   push_i,
  input  entry_t push_entry_i,
  output logic   push_ready_o,
  output logic   pop_valid_o,
  output entry_t pop_entry_o,
  input  logic   pop_i
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);
  localparam logic [PtrW-1:0] PtrLast = PtrW'(Depth - 1);
  localparam logic [CntW-1:0] CntFull = CntW'(Depth);

  entry_t          mem_q [Depth];
  logic [PtrW-1:0] wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0] rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0] count_q, count_d;
  logic            do_push, do_pop;

  assign push_ready_o = (count_q != CntFull);
  assign pop_valid_o  = (count_q != '0);
  assign pop_entry_o  = mem_q[rd_ptr_q];
  assign do_push      = push_i && push_ready_o;
  assign do_pop       = pop_i && pop_valid_o;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == PtrLast) ? '0 : wr_ptr_q + PtrW'(1);
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == PtrLast) ? '0 : rd_ptr_q + PtrW'(1);
    end
    if (do_push && !do_pop) begin
      count_d = count_q + CntW'(1);
    end else if (do_pop && !do_push) begin
      count_d = count_q - CntW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= push_entry_i;
    end
  end

endmodule

// ===== design/frcb_back.sv =====
// back end: walks the fourteen command words of each queued request into an
// output register, or one error word for a rejected request; uses frcb_pkg
module frcb_back import frcb_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  cfg_t       cfg_i,
  input  logic       head_valid_i,
  input  entry_t     head_entry_i,
  output logic       pop_o,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output logic [7:0] command_byte_o,
  output logic       error_o,
  output logic       last_o
);

  logic [3:0] idx_q, idx_d;
  logic       out_valid_q, out_valid_d;
  logic [7:0] byte_q, byte_d;
  logic       err_q, last_q;
  logic       slot_free, emit, is_last;
  logic [7:0] trk_seek_byte;

  assign slot_free = !out_valid_q || out_ready_i;
  assign emit      = head_valid_i && slot_free;
  assign is_last   = head_entry_i.err || (idx_q == IDX_READ_DTL);
  assign pop_o     = emit && is_last;

  assign trk_seek_byte = cfg_i.track_stretch ? {head_entry_i.track[6:0], 1'b0}
                                             : head_entry_i.track;

  always_comb begin
    case (idx_q)
      IDX_RECAL_OP:    byte_d = CMD_RECALIBRATE;
      IDX_RECAL_DRIVE: byte_d = {6'd0, head_entry_i.drive};
      IDX_SEEK_OP:     byte_d = CMD_SEEK;
      IDX_SEEK_SEL:    byte_d = {4'd0, head_entry_i.head, head_entry_i.drive};
      IDX_SEEK_TRACK:  byte_d = trk_seek_byte;
      IDX_READ_OP:     byte_d = CMD_READ;
      IDX_READ_DRIVE:  byte_d = {6'd0, head_entry_i.drive};
      IDX_READ_TRACK:  byte_d = head_entry_i.track;
      IDX_READ_HEAD:   byte_d = {6'd0, head_entry_i.head};
      IDX_READ_SECTOR: byte_d = {2'd0, head_entry_i.sector};
      IDX_READ_SIZE:   byte_d = SIZE_CODE_512;
      IDX_READ_EOT:    byte_d = {2'd0, cfg_i.sectors_per_track};
      IDX_READ_GAP:    byte_d = cfg_i.gap_length;
      IDX_READ_DTL:    byte_d = DATA_LENGTH;
      default:         byte_d = 8'h00;
    endcase
    if (head_entry_i.err) begin
      byte_d = 8'h00;
    end
  end

  always_comb begin
    idx_d       = idx_q;
    out_valid_d = out_valid_q;
    if (emit) begin
      idx_d       = is_last ? IDX_RECAL_OP : idx_q + 4'd1;
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q       <= IDX_RECAL_OP;
      out_valid_q <= 1'b0;
    end else begin
      idx_q       <= idx_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit) begin
      byte_q <= byte_d;
      err_q  <= head_entry_i.err;
      last_q <= is_last;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign command_byte_o = byte_q;
  assign error_o        = err_q;
  assign last_o         = last_q;

endmodule

// ===== design/floppy_read_command_builder.sv =====
// top level of the floppy read command builder
// holds the configuration registers and joins frcb_front, frcb_fifo and frcb_back
//
// A request (drive, linear sector, buffer flag) is checked against
// heads*tracks*sectors and either rejected with one error word or turned into
// fourteen controller words: recalibrate, seek and read. Output words leave at
// one per cycle from an output register while out_ready_i is high, so a valid
// request gives fourteen output words and a rejected one gives one. The front
// end splits the sector number in a restoring divider at one quotient bit per
// cycle, hands the entry to the queue and runs ahead through a QueueDepth-entry
// queue, so it can split new requests while earlier words still go out.
// Configuration is written through cfg_we_i, cfg_index_i and cfg_data_i and
// must only change while no request is in flight.
module floppy_read_command_builder import frcb_pkg::*; #(
  parameter int unsigned QueueDepth = 2
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_index_i,
  input  logic [CfgDataW-1:0] cfg_data_i,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  logic [1:0]          drive_i,
  input  logic [14:0]         sector_number_i,
  input  logic                buffer_present_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output logic [7:0]          command_byte_o,
  output logic                error_o,
  output logic                last_o
);

  cfg_t   cfg_q;
  logic   push, push_ready, head_valid, pop;
  entry_t push_entry, head_entry;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.sectors_per_track <= SPT_RESET;
      cfg_q.head_count        <= HEADS_RESET;
      cfg_q.track_count       <= TRACKS_RESET;
      cfg_q.track_stretch     <= STRETCH_RESET;
      cfg_q.gap_length        <= GAP_RESET;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        REG_SECTORS_PER_TRACK: cfg_q.sectors_per_track <= cfg_data_i[5:0];
        REG_HEAD_COUNT:        cfg_q.head_count        <= cfg_data_i[1:0];
        REG_TRACK_COUNT:       cfg_q.track_count       <= cfg_data_i;
        REG_TRACK_STRETCH:     cfg_q.track_stretch     <= cfg_data_i[0];
        REG_GAP_LENGTH:        cfg_q.gap_length        <= cfg_data_i;
        default: ;
      endcase
    end
  end

  frcb_front u_front (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_i            (cfg_q),
    .in_valid_i       (in_valid_i),
    .in_ready_o       (in_ready_o),
    .drive_i          (drive_i),
    .sector_number_i  (sector_number_i),
    .buffer_present_i (buffer_present_i),
    .push_o           (push),
    .push_entry_o     (push_entry),
    .push_ready_i     (push_ready)
  );

  frcb_fifo #(
    .Depth (QueueDepth)
  ) u_fifo (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_i       (push),
    .push_entry_i (push_entry),
    .push_ready_o (push_ready),
    .pop_valid_o  (head_valid),
    .pop_entry_o  (head_entry),
    .pop_i        (pop)
  );

  frcb_back u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_i          (cfg_q),
    .head_valid_i   (head_valid),
    .head_entry_i   (head_entry),
    .pop_o          (pop),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .command_byte_o (command_byte_o),
    .error_o        (error_o),
    .last_o         (last_o)
  );

endmodule

// ===== design/frcb_chk.sv =====
// port-level checker for the floppy read command builder, bound to the top level
// uses frcb_pkg for the command codes
module frcb_chk import frcb_pkg::*; (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       out_valid_o,
  input logic       out_ready_i,
  input logic [7:0] command_byte_o,
  input logic       error_o,
  input logic       last_o
);

  // an error word stands alone and carries a zero byte
  a_err_alone: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && error_o |-> last_o && (command_byte_o == 8'h00))
    else $error("error word not single or not zero");

  // the final word of a command sequence is the data length byte
  a_last_dtl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && last_o && !error_o |-> command_byte_o == DATA_LENGTH)
    else $error("last command word is not the data length");

  // after the closing word of a request a new one opens with recalibrate or an error
  a_seq_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_ready_i && last_o ##1 out_valid_o && !error_o
      |-> command_byte_o == CMD_RECALIBRATE)
    else $error("command sequence does not open with recalibrate");

  // a stalled word holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(command_byte_o)
      && $stable(error_o) && $stable(last_o))
    else $error("output word changed while stalled");

endmodule

bind floppy_read_command_builder frcb_chk u_frcb_chk (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .out_valid_o    (out_valid_o),
  .out_ready_i    (out_ready_i),
  .command_byte_o (command_byte_o),
  .error_o        (error_o),
  .last_o         (last_o)
);
